/* rtl/bubm_pkg.sv */
// shared types and constants for the block usage bitmap marker
// no dependencies
package bubm_pkg;

   localparam int unsigned BLOCK_W = 32;
   localparam int unsigned WIDX_W = 12;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned BIT_W = 5;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned BOOT_W = 8;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_MARK = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_IN_USE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_BLOCK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOT_OFFSET = 2'd2;

   localparam logic [BLOCK_W-1:0] FIRST_BLOCK_RST = 32'd2;
   localparam logic [BLOCK_W-1:0] BLOCK_COUNT_RST = 32'd1760;
   localparam logic [BOOT_W-1:0] BOOT_OFFSET_RST = 8'd2;

   typedef struct packed {
      logic [BLOCK_W-1:0] first_block;
      logic [BLOCK_W-1:0] block_count;
      logic [BOOT_W-1:0]  boot_offset;
   } cfg_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_DECODE,
      S_SWEEP,
      S_LOOKUP
   } state_type;

endpackage

/* rtl/bubm_map_mem.sv */
// bitmap word store, one write port and one registered read port
// no package dependencies
module bubm_map_mem #(
   parameter int unsigned DEPTH = 4096,
   parameter int unsigned AW = 12,
   parameter int unsigned DW = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bubm_ctrl.sv */
// request sequencer: decode, read-modify-write of the bitmap, fill sweeps
// uses bubm_pkg; drives the port of bubm_map_mem
module bubm_ctrl #(
   parameter int unsigned MAP_WORDS = 4096,
   parameter int unsigned AW = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bubm_pkg::cfg_type             cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_command,
   input  logic [bubm_pkg::BLOCK_W-1:0]  req_block_number,
   input  logic [bubm_pkg::WIDX_W-1:0]   req_word_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [bubm_pkg::WORD_W-1:0]   rsp_word_data,
   output logic                          mem_wr_en,
   output logic [AW-1:0]                 mem_wr_addr,
   output logic [bubm_pkg::WORD_W-1:0]   mem_wr_data,
   output logic [AW-1:0]                 mem_rd_addr,
   input  logic [bubm_pkg::WORD_W-1:0]   mem_rd_data
);

   localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);
   localparam logic [31:0] DEPTH32 = 32'(MAP_WORDS);

   bubm_pkg::state_type state_ff, state_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [bubm_pkg::BLOCK_W-1:0] blk_ff, blk_in;
   logic [bubm_pkg::WIDX_W-1:0] widx_ff, widx_in;
   logic range_ff, range_in;
   logic [bubm_pkg::BIT_W-1:0] bit_ff, bit_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [bubm_pkg::WORD_W-1:0] rsp_data_ff, rsp_data_in;

   logic [31:0] bit_index;
   logic [31:0] word_num;
   logic [31:0] widx32;
   logic out_free;
   logic [bubm_pkg::WORD_W-1:0] mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bubm_pkg::S_INIT;
         sweep_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      blk_ff <= blk_in;
      widx_ff <= widx_in;
      range_ff <= range_in;
      bit_ff <= bit_in;
      addr_ff <= addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      bit_index = blk_ff - {24'd0, cfg.boot_offset};
      word_num = {5'd0, bit_index[31:5]};
      widx32 = {20'd0, widx_ff};
      out_free = !rsp_valid_ff || rsp_ready;
      mask = bubm_pkg::WORD_W'(1) << bit_ff;

      state_in = state_ff;
      sweep_in = sweep_ff;
      cmd_in = cmd_ff;
      blk_in = blk_ff;
      widx_in = widx_ff;
      range_in = range_ff;
      bit_in = bit_ff;
      addr_in = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in = rsp_data_ff;
      req_ready = 1'b0;
      mem_wr_en = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_addr = addr_ff;

      unique case (state_ff)
         bubm_pkg::S_INIT, bubm_pkg::S_SWEEP: begin
            mem_wr_en = 1'b1;
            mem_wr_addr = sweep_ff;
            mem_wr_data = '1;
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               state_in = (state_ff == bubm_pkg::S_INIT) ? bubm_pkg::S_IDLE
                                                         : bubm_pkg::S_LOOKUP;
            end
         end
         bubm_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in = req_command;
               blk_in = req_block_number;
               widx_in = req_word_index;
               state_in = bubm_pkg::S_DECODE;
            end
         end
         bubm_pkg::S_DECODE: begin
            bit_in = bit_index[bubm_pkg::BIT_W-1:0];
            if (cmd_ff == bubm_pkg::CMD_READ) begin
               range_in = widx32 >= DEPTH32;
               addr_in = widx32[AW-1:0];
            end else begin
               range_in = (blk_ff < cfg.first_block) || (blk_ff >= cfg.block_count)
                          || (word_num >= DEPTH32);
               addr_in = word_num[AW-1:0];
            end
            mem_rd_addr = addr_in;
            state_in = (cmd_ff == bubm_pkg::CMD_CLEAR) ? bubm_pkg::S_SWEEP
                                                       : bubm_pkg::S_LOOKUP;
         end
         bubm_pkg::S_LOOKUP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = bubm_pkg::STAT_OK;
               rsp_data_in = '0;
               state_in = bubm_pkg::S_IDLE;
               unique case (cmd_ff)
                  bubm_pkg::CMD_MARK: begin
                     if (range_ff) begin
                        rsp_status_in = bubm_pkg::STAT_RANGE;
                     end else if ((mem_rd_data & mask) == '0) begin
                        rsp_status_in = bubm_pkg::STAT_IN_USE;
                     end else begin
                        mem_wr_en = 1'b1;
                        mem_wr_data = mem_rd_data & ~mask;
                     end
                  end
                  bubm_pkg::CMD_READ: begin
                     if (range_ff) begin
                        rsp_status_in = bubm_pkg::STAT_RANGE;
                     end else begin
                        rsp_data_in = mem_rd_data;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = bubm_pkg::S_INIT;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_word_data = rsp_data_ff;

endmodule

/* rtl/block_usage_bitmap_marker.sv */
// top level: configuration registers, stream ports, sequencer and bitmap store
// uses bubm_pkg, bubm_ctrl and bubm_map_mem
//
// channel   dir  handshake             payload
// req       in   req_tvalid/tready     tuser: command; tdata: block_number, word_index
// rsp       out  rsp_tvalid/tready     tdata: status, word_data
// csr       in   csr_we (no wait)      csr_index, csr_wdata
//
// a mark or read is decoded after accept, with the memory read, then checked and
// written back into the response register; the next request is accepted only afterwards
// a clear rewrites every word, one per cycle, then loads the response register
// after reset a fill pass rewrites every word before the first request is accepted
// a pending response is held in the output register and stalls only the final step
module block_usage_bitmap_marker #(
   parameter int unsigned MAP_WORDS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // block_number[31:0], word_index[43:32], zero fill
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status[1:0], word_data[33:2], zero fill
   input  logic        csr_we,
   input  logic [bubm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   bubm_pkg::cfg_type cfg_ff;

   logic mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [bubm_pkg::WORD_W-1:0] mem_wr_data;
   logic [AW-1:0] mem_rd_addr;
   logic [bubm_pkg::WORD_W-1:0] mem_rd_data;
   logic [1:0] rsp_status;
   logic [bubm_pkg::WORD_W-1:0] rsp_word_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_block <= bubm_pkg::FIRST_BLOCK_RST;
         cfg_ff.block_count <= bubm_pkg::BLOCK_COUNT_RST;
         cfg_ff.boot_offset <= bubm_pkg::BOOT_OFFSET_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            bubm_pkg::CSR_FIRST_BLOCK: cfg_ff.first_block <= csr_wdata;
            bubm_pkg::CSR_BLOCK_COUNT: cfg_ff.block_count <= csr_wdata;
            bubm_pkg::CSR_BOOT_OFFSET: cfg_ff.boot_offset <= csr_wdata[bubm_pkg::BOOT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   bubm_ctrl #(
      .MAP_WORDS(MAP_WORDS),
      .AW(AW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_command(req_tuser),
      .req_block_number(req_tdata[31:0]),
      .req_word_index(req_tdata[43:32]),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_status(rsp_status),
      .rsp_word_data(rsp_word_data),
      .mem_wr_en(mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_data(mem_wr_data),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_data(mem_rd_data)
   );

   bubm_map_mem #(
      .DEPTH(MAP_WORDS),
      .AW(AW),
      .DW(bubm_pkg::WORD_W)
   ) u_map_mem (
      .clock(clock),
      .wr_en(mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   assign rsp_tdata = {6'd0, rsp_word_data, rsp_status};

endmodule
